FILE: design/ssc_pkg.sv
package ssc_pkg;

	// Default width of the saturating byte counter.
	localparam int COUNT_BITS_DEF = 25;

	// Widths of the configuration port and of the size registers.
	localparam int CFG_INDEX_BITS = 3;
	localparam int CFG_DATA_BITS  = 32;
	localparam int SIZE_BITS      = 25;

	// Header layout, byte offsets from the start of the file.
	localparam int HDR_BYTES     = 72;
	localparam int VERSION_POS   = 4;
	localparam int ROM_TEXT_POS  = 8;
	localparam int APP_TEXT_POS  = 24;
	localparam int TICK_POS      = 56;
	localparam int LENGTH_POS    = 64;
	localparam int CRC_POS       = 68;

	localparam logic [31:0] CRC_ALL_ONES = 32'hFFFF_FFFF;

	// Reflected CRC-32 (polynomial 0xEDB88320), one entry per low nibble.
	localparam logic [31:0] CRC_NIB_TBL [16] = '{
		32'h0000_0000, 32'h1DB7_1064, 32'h3B6E_20C8, 32'h26D9_30AC,
		32'h76DC_4190, 32'h6B6B_51F4, 32'h4DB2_6158, 32'h5005_713C,
		32'hEDB8_8320, 32'hF00F_9344, 32'hD6D6_A3E8, 32'hCB61_B38C,
		32'h9B64_C2B0, 32'h86D3_D2D4, 32'hA00A_E278, 32'hBDBD_F21C
	};

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_TRUNCATED = 3'd1,
		ST_FORMAT    = 3'd2,
		ST_VERSION   = 3'd3,
		ST_SIZE      = 3'd4,
		ST_CAPACITY  = 3'd5,
		ST_CHECKSUM  = 3'd6
	} status_t;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		CFG_MAGIC    = 3'd0,
		CFG_VERSION  = 3'd1,
		CFG_MAX_PAY  = 3'd2,
		CFG_CAPACITY = 3'd3
	} cfg_reg_t;

	// Header fields as collected so far.
	typedef struct packed {
		logic [31:0] magic;
		logic [31:0] version;
		logic [63:0] tick;
		logic [31:0] length;
		logic [31:0] crc;
		logic        rom_end;
		logic        app_end;
	} hdr_t;

	// Configuration as seen by the status logic.
	typedef struct packed {
		logic [31:0]          magic;
		logic [31:0]          version;
		logic [SIZE_BITS-1:0] max_payload;
		logic [SIZE_BITS-1:0] capacity;
	} cfg_t;

	// One byte through the nibble table, low nibble first.
	function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
		logic [31:0] x;
		x = c ^ {24'd0, b};
		x = (x >> 4) ^ CRC_NIB_TBL[x[3:0]];
		x = (x >> 4) ^ CRC_NIB_TBL[x[3:0]];
		return x;
	endfunction

endpackage

FILE: design/ssc_hdr.sv
module ssc_hdr #(
	parameter int COUNT_BITS = ssc_pkg::COUNT_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  logic                  last,
	input  logic [7:0]            data_b,
	output ssc_pkg::hdr_t         hdr_nxt,
	output logic [COUNT_BITS-1:0] total_nxt,
	output logic                  payload_take
);
	import ssc_pkg::*;

	localparam int CmpW = ((COUNT_BITS > 32) ? COUNT_BITS : 32) + 1;

	logic [COUNT_BITS-1:0] count_q;
	hdr_t                  hdr_q;
	logic [6:0]            pos7;
	logic                  in_hdr;

	assign pos7   = count_q[6:0];
	assign in_hdr = count_q < COUNT_BITS'(HDR_BYTES);

	// Payload bytes follow the header and stop after the declared length.
	assign payload_take = !in_hdr &&
		((CmpW'(count_q) - CmpW'(HDR_BYTES)) < CmpW'(hdr_q.length));

	assign total_nxt = (&count_q) ? count_q : count_q + COUNT_BITS'(1);

	always_comb begin
		hdr_nxt = hdr_q;
		if (in_hdr) begin
			if (pos7 < 7'(VERSION_POS)) begin
				hdr_nxt.magic[{pos7[1:0], 3'b000} +: 8] = data_b;
			end else if (pos7 < 7'(ROM_TEXT_POS)) begin
				hdr_nxt.version[{pos7[1:0], 3'b000} +: 8] = data_b;
			end else if (pos7 < 7'(APP_TEXT_POS)) begin
				if (data_b == 8'd0) hdr_nxt.rom_end = 1'b1;
			end else if (pos7 < 7'(TICK_POS)) begin
				if (data_b == 8'd0) hdr_nxt.app_end = 1'b1;
			end else if (pos7 < 7'(LENGTH_POS)) begin
				hdr_nxt.tick[{pos7[2:0], 3'b000} +: 8] = data_b;
			end else if (pos7 < 7'(CRC_POS)) begin
				hdr_nxt.length[{pos7[1:0], 3'b000} +: 8] = data_b;
			end else begin
				hdr_nxt.crc[{pos7[1:0], 3'b000} +: 8] = data_b;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			hdr_q   <= '0;
		end else if (step) begin
			if (last) begin
				count_q <= '0;
				hdr_q   <= '0;
			end else begin
				count_q <= total_nxt;
				hdr_q   <= hdr_nxt;
			end
		end
	end

endmodule

FILE: design/ssc_crc32.sv
module ssc_crc32 (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step,
	input  logic        last,
	input  logic        take,
	input  logic [7:0]  data_b,
	output logic [31:0] crc_nxt
);
	import ssc_pkg::*;

	logic [31:0] crc_q;

	assign crc_nxt = take ? crc_byte(crc_q, data_b) : crc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= CRC_ALL_ONES;
		end else if (step) begin
			crc_q <= last ? CRC_ALL_ONES : crc_nxt;
		end
	end

endmodule

FILE: design/ssc_judge.sv
module ssc_judge #(
	parameter int COUNT_BITS = ssc_pkg::COUNT_BITS_DEF
) (
	input  ssc_pkg::hdr_t         hdr,
	input  ssc_pkg::cfg_t         cfg,
	input  logic [COUNT_BITS-1:0] total,
	input  logic [31:0]           computed,
	output ssc_pkg::status_t      status
);
	import ssc_pkg::*;

	localparam int CmpW = ((COUNT_BITS > 32) ? COUNT_BITS : 32) + 1;

	logic [CmpW-1:0] total_w;
	logic [CmpW-1:0] expect_w;

	assign total_w  = CmpW'(total);
	assign expect_w = CmpW'(HDR_BYTES) + CmpW'(hdr.length);

	// Checks in the order the file format defines them; the first failure wins.
	always_comb begin
		if (total_w < CmpW'(HDR_BYTES)) begin
			status = ST_TRUNCATED;
		end else if (hdr.magic != cfg.magic) begin
			status = ST_FORMAT;
		end else if (hdr.version != cfg.version) begin
			status = ST_VERSION;
		end else if (!hdr.rom_end || !hdr.app_end) begin
			status = ST_FORMAT;
		end else if (hdr.length > 32'(cfg.max_payload)) begin
			status = ST_SIZE;
		end else if (hdr.length > 32'(cfg.capacity)) begin
			status = ST_CAPACITY;
		end else if (total_w != expect_w) begin
			status = (total_w < expect_w) ? ST_TRUNCATED : ST_SIZE;
		end else if (computed != hdr.crc) begin
			status = ST_CHECKSUM;
		end else begin
			status = ST_OK;
		end
	end

endmodule

FILE: design/save_state_stream_checker_top.sv
// Save-state stream checker.
// File bytes arrive one word at a time on the byte channel (data_byte, with
// last_byte set on the final byte). Each word is parsed against the 72-byte
// header layout, and the declared payload bytes that follow run through a
// reflected CRC-32. The final byte of a file yields one word on the result
// channel: a status code plus the header tick, length, stored CRC and the
// computed CRC. Non-final bytes yield nothing.
// A byte word waits in an input register and is folded into the parse
// state when it leaves that register. The same edge loads the result
// register on a final byte, so result_valid rises as that byte leaves it.
// One byte is taken every cycle; the only stall comes when a final byte
// is waiting and the result register still holds an untaken word, which
// holds byte_ready low until result_ready frees the register.
// The configuration channel (cfg_index, cfg_data) is always ready and writes
// one register per word; indexes past the last register are ignored.
// Reset clears the parse state, the CRC to all ones and the handshakes, and
// loads the configuration defaults. After each final byte the parse state
// returns to its reset values while the configuration is kept.
module save_state_stream_checker_top #(
	parameter int COUNT_BITS = ssc_pkg::COUNT_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [ssc_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
	input  logic [ssc_pkg::CFG_DATA_BITS-1:0]   cfg_data,
	input  logic                                byte_valid,
	output logic                                byte_ready,
	input  logic [7:0]                          data_byte,
	input  logic                                last_byte,
	output logic                                result_valid,
	input  logic                                result_ready,
	output logic [2:0]                          status,
	output logic [63:0]                         tick,
	output logic [31:0]                         declared_length,
	output logic [31:0]                         stored_crc,
	output logic [31:0]                         computed_crc
);
	import ssc_pkg::*;

	// Configuration registers.
	cfg_t cfg_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.magic       <= 32'd0;
			cfg_q.version     <= 32'd1;
			cfg_q.max_payload <= SIZE_BITS'(1 << 24);
			cfg_q.capacity    <= SIZE_BITS'(1 << 24);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_MAGIC:    cfg_q.magic       <= cfg_data;
				CFG_VERSION:  cfg_q.version     <= cfg_data;
				CFG_MAX_PAY:  cfg_q.max_payload <= cfg_data[SIZE_BITS-1:0];
				CFG_CAPACITY: cfg_q.capacity    <= cfg_data[SIZE_BITS-1:0];
				default: ;
			endcase
		end
	end

	// Input register. It moves on unless it holds a final byte while the
	// result register is occupied and not being drained.
	logic       valid_s1;
	logic       last_s1;
	logic [7:0] data_s1;
	logic       adv_s1;
	logic       result_valid_q;

	assign adv_s1     = valid_s1 && (!last_s1 || !result_valid_q || result_ready);
	assign byte_ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_ready) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_valid && byte_ready) begin
			data_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	// Header parse, byte count and payload CRC.
	hdr_t                  hdr_nxt;
	logic [COUNT_BITS-1:0] total_nxt;
	logic                  payload_take;
	logic [31:0]           crc_nxt;
	status_t               status_nxt;

	ssc_hdr #(
		.COUNT_BITS(COUNT_BITS)
	) u_hdr (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (adv_s1),
		.last        (last_s1),
		.data_b      (data_s1),
		.hdr_nxt     (hdr_nxt),
		.total_nxt   (total_nxt),
		.payload_take(payload_take)
	);

	ssc_crc32 u_crc (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (adv_s1),
		.last   (last_s1),
		.take   (payload_take),
		.data_b (data_s1),
		.crc_nxt(crc_nxt)
	);

	ssc_judge #(
		.COUNT_BITS(COUNT_BITS)
	) u_judge (
		.hdr     (hdr_nxt),
		.cfg     (cfg_q),
		.total   (total_nxt),
		.computed(crc_nxt ^ CRC_ALL_ONES),
		.status  (status_nxt)
	);

	// Result register, loaded by a final byte.
	status_t     status_q;
	logic [63:0] tick_q;
	logic [31:0] length_q;
	logic [31:0] stored_q;
	logic [31:0] computed_q;
	logic        load_res;

	assign load_res = adv_s1 && last_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (load_res) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_res) begin
			status_q   <= status_nxt;
			tick_q     <= hdr_nxt.tick;
			length_q   <= hdr_nxt.length;
			stored_q   <= hdr_nxt.crc;
			computed_q <= crc_nxt ^ CRC_ALL_ONES;
		end
	end

	assign result_valid    = result_valid_q;
	assign status          = status_q;
	assign tick            = tick_q;
	assign declared_length = length_q;
	assign stored_crc      = stored_q;
	assign computed_crc    = computed_q;

	// A new result word only appears after a final byte left the input register.
	a_rise_from_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid_q) |-> $past(load_res))
		else $error("result word appeared without a final byte");

	// A waiting result must never be overwritten by the next final byte.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid_q && !result_ready && valid_s1 && last_s1) |-> !adv_s1)
		else $error("final byte advanced over an untaken result");

	// An empty input register always takes a byte.
	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> byte_ready)
		else $error("input register empty but not ready");

	// A good file means the two checksums agree.
	a_ok_crc: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid_q && (status_q == ST_OK)) |-> (computed_q == stored_q))
		else $error("ok status with mismatching checksum");

endmodule

FILE: test/tb_save_state_stream_checker_top.sv
`timescale 1ns / 1ps

// Testbench for the save-state stream checker.
// Whole files are pushed through the byte channel one word per handshake,
// and every accepted byte is also folded into a local parser that works out
// the verdict the block should give on the final byte of each file. The
// result channel is compared field by field against the oldest pending
// verdict. A directed table opens the run, and it is followed by random
// phases, each with its own register setting.
module tb_save_state_stream_checker_top;
	import ssc_pkg::*;

	localparam int CNT_BITS = COUNT_BITS_DEF;
	localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;

	// Spare register index, one past the last real register.
	localparam logic [CFG_INDEX_BITS-1:0] CFG_FIRST_UNUSED =
		CFG_INDEX_BITS'(int'(CFG_CAPACITY) + 1);

	// How the filler bytes of a file are chosen.
	localparam int FILL_RAND = 0;
	localparam int FILL_ZERO = 1;
	localparam int FILL_ONES = 2;

	// The result register sits behind the input register, so the settle
	// time covers anything still in flight.
	localparam int SETTLE_CYCLES = 6;

	// Random phases run until both of these are reached.
	localparam int RANDOM_BYTES = 1560;
	localparam int RANDOM_FILES = 22;
	localparam int CALM_FILES   = 2;

	typedef struct packed {
		status_t     status;
		logic [63:0] tick;
		logic [31:0] length;
		logic [31:0] stored;
		logic [31:0] computed;
	} verdict_t;

	// One file to send. The header fields are written as given, so a file
	// can carry a wrong magic or version on purpose. cut below HDR_BYTES ends
	// the file inside the header; otherwise n_pay bytes follow the header.
	typedef struct packed {
		int          cfg_sel;
		logic [31:0] magic;
		logic [31:0] version;
		logic        rom_zero;
		logic        app_zero;
		logic [63:0] tick;
		logic [31:0] length;
		logic        crc_good;
		int          cut;
		int          n_pay;
		int          fill;
		logic        typed;
		status_t     st;
	} file_spec_t;

	typedef struct packed {
		logic [31:0] magic;
		logic [31:0] version;
		logic [31:0] max_pay;
		logic [31:0] cap;
	} cfg_set_t;

	typedef struct packed {
		logic    typed;
		status_t st;
	} file_tag_t;

	// Register settings used by the directed table.
	localparam int CFG_SETS = 3;
	localparam cfg_set_t cfg_tbl [CFG_SETS] = '{
		'{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000},
		'{32'h5AA5_C33C, 32'h0000_0002, 32'hFFFF_FFFF, 32'h0000_0004},
		'{32'h0000_0000, 32'h0000_0001, 32'h0100_0000, 32'h0100_0000}
	};

	// Directed files. Columns: register set (-1 keeps the current one), magic,
	// version, zero in the short text field, zero in the long text field,
	// tick, declared length, stored CRC correct, cut, payload bytes, filler,
	// status typed in, typed status.
	localparam int DIR_ROWS = 20;
	localparam file_spec_t dir_tbl [DIR_ROWS] = '{
		// Fresh out of reset with the default registers: empty payload is fine.
		'{-1, 0, 1, 1, 1, 0, 0, 1, HDR_BYTES, 0, FILL_RAND, 1, ST_OK},
		// A file of one byte, and a file one byte short of the header.
		'{-1, 32'hFFFF_FFFF, 1, 1, 1, 0, 0, 1, 1, 0, FILL_ONES, 1, ST_TRUNCATED},
		'{-1, 0, 1, 1, 1, '1, 0, 1, HDR_BYTES - 1, 0, FILL_RAND, 1, ST_TRUNCATED},
		// Header checks in the order the block applies them.
		'{-1, 1, 1, 1, 1, 0, 0, 1, HDR_BYTES, 0, FILL_RAND, 1, ST_FORMAT},
		'{-1, 0, 0, 1, 1, 0, 0, 1, HDR_BYTES, 0, FILL_RAND, 1, ST_VERSION},
		'{-1, 0, 1, 0, 1, 0, 0, 1, HDR_BYTES, 0, FILL_RAND, 1, ST_FORMAT},
		'{-1, 0, 1, 1, 0, 0, 0, 1, HDR_BYTES, 0, FILL_RAND, 1, ST_FORMAT},
		'{-1, 0, 1, 1, 1, 0, 32'hFFFF_FFFF, 1, HDR_BYTES, 2, FILL_RAND, 1, ST_SIZE},
		// Length exactly at the ceiling passes the size check, one above does not.
		'{-1, 0, 1, 1, 1, 0, 32'h0100_0000, 1, HDR_BYTES, 3, FILL_RAND, 1, ST_TRUNCATED},
		'{-1, 0, 1, 1, 1, 0, 32'h0100_0001, 1, HDR_BYTES, 3, FILL_RAND, 1, ST_SIZE},
		// Payload shorter and longer than declared, then a bad stored CRC.
		'{-1, 0, 1, 1, 1, 0, 5, 1, HDR_BYTES, 3, FILL_RAND, 1, ST_TRUNCATED},
		'{-1, 0, 1, 1, 1, 0, 5, 1, HDR_BYTES, 8, FILL_RAND, 1, ST_SIZE},
		'{-1, 0, 1, 1, 1, 0, 6, 0, HDR_BYTES, 6, FILL_RAND, 1, ST_CHECKSUM},
		// Byte extremes through the CRC.
		'{-1, 0, 1, 1, 1, '1, 16, 1, HDR_BYTES, 16, FILL_ONES, 1, ST_OK},
		'{-1, 0, 1, 1, 1, 0, 16, 1, HDR_BYTES, 16, FILL_ZERO, 1, ST_OK},
		// All-ones tag and version, with both size registers at zero.
		'{0, '1, '1, 1, 1, 0, 0, 1, HDR_BYTES, 0, FILL_RAND, 1, ST_OK},
		'{-1, '1, '1, 1, 1, 0, 1, 1, HDR_BYTES, 1, FILL_RAND, 1, ST_SIZE},
		// Ceiling written as all ones (kept to 25 bits) above a small buffer.
		'{1, 32'h5AA5_C33C, 2, 1, 1, 0, 5, 1, HDR_BYTES, 5, FILL_RAND, 1, ST_CAPACITY},
		'{-1, 32'h5AA5_C33C, 2, 1, 1, 0, 4, 1, HDR_BYTES, 4, FILL_RAND, 1, ST_OK},
		// Back to the defaults; this one is left to the local parser.
		'{2, 0, 1, 1, 1, 64'h0123_4567_89AB_CDEF, 3, 1, HDR_BYTES, 3, FILL_RAND, 0, ST_OK}
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_INDEX_BITS-1:0] cfg_index = CFG_MAGIC;
	logic [CFG_DATA_BITS-1:0] cfg_data = '0;
	logic byte_valid = 1'b0;
	logic byte_ready;
	logic [7:0] data_byte = 8'h00;
	logic last_byte = 1'b0;
	logic result_valid;
	logic result_ready = 1'b0;
	logic [2:0] status;
	logic [63:0] tick;
	logic [31:0] declared_length;
	logic [31:0] stored_crc;
	logic [31:0] computed_crc;

	save_state_stream_checker_top #(
		.COUNT_BITS(CNT_BITS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.byte_valid(byte_valid),
		.byte_ready(byte_ready),
		.data_byte(data_byte),
		.last_byte(last_byte),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.status(status),
		.tick(tick),
		.declared_length(declared_length),
		.stored_crc(stored_crc),
		.computed_crc(computed_crc)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Register copies, loaded with the values the block takes at reset.
	logic [31:0] want_magic = 32'h0000_0000;
	logic [31:0] want_version = 32'h0000_0001;
	logic [SIZE_BITS-1:0] limit_payload = 25'h100_0000;
	logic [SIZE_BITS-1:0] limit_capacity = 25'h100_0000;

	// Parse state of the local copy of the checker.
	logic [CNT_BITS-1:0] seen_count;
	logic [31:0] got_magic;
	logic [31:0] got_version;
	logic [63:0] got_tick;
	logic [31:0] got_length;
	logic [31:0] got_crc;
	logic rom_term;
	logic app_term;
	logic [31:0] run_crc;

	verdict_t expected_verdicts[$];
	file_tag_t file_tags[$];
	int mismatches = 0;
	int bytes_sent = 0;
	int files_sent = 0;
	bit tx_stalls = 1'b1;
	bit rx_stalls = 1'b1;
	bit calm = 1'b0;

	// Reflected CRC-32, one bit at a time.
	function automatic logic [31:0] crc32_step(input logic [31:0] c, input logic [7:0] b);
		logic [31:0] x;
		x = c ^ {24'd0, b};
		for (int k = 0; k < 8; k++)
			x = x[0] ? ((x >> 1) ^ CRC_POLY) : (x >> 1);
		return x;
	endfunction

	function automatic void restart_parse();
		seen_count = '0;
		got_magic = '0;
		got_version = '0;
		got_tick = '0;
		got_length = '0;
		got_crc = '0;
		rom_term = 1'b0;
		app_term = 1'b0;
		run_crc = CRC_ALL_ONES;
	endfunction

	// Folds one accepted byte into the parse state. On the final byte of a
	// file it fills in the verdict, clears the parse state and returns 1.
	function automatic bit absorb_byte(input logic [7:0] b, input logic fin,
			output verdict_t v);
		longint pos;
		longint total;
		int p;
		logic [31:0] crc_out;
		v = '0;
		pos = longint'(seen_count);
		if (pos < HDR_BYTES) begin
			p = int'(pos);
			if (p < VERSION_POS)
				got_magic[8*p +: 8] = b;
			else if (p < ROM_TEXT_POS)
				got_version[8*(p - VERSION_POS) +: 8] = b;
			else if (p < APP_TEXT_POS) begin
				if (b == 8'h00)
					rom_term = 1'b1;
			end else if (p < TICK_POS) begin
				if (b == 8'h00)
					app_term = 1'b1;
			end else if (p < LENGTH_POS)
				got_tick[8*(p - TICK_POS) +: 8] = b;
			else if (p < CRC_POS)
				got_length[8*(p - LENGTH_POS) +: 8] = b;
			else
				got_crc[8*(p - CRC_POS) +: 8] = b;
		end else if (pos - HDR_BYTES < longint'(got_length)) begin
			// Only the declared payload enters the CRC; trailing bytes are
			// counted and nothing more.
			run_crc = crc32_step(run_crc, b);
		end
		// The counter sticks at its ceiling.
		if (seen_count != '1)
			seen_count = seen_count + 1'b1;
		if (!fin)
			return 1'b0;

		total = longint'(seen_count);
		crc_out = run_crc ^ CRC_ALL_ONES;
		if (total < HDR_BYTES)
			v.status = ST_TRUNCATED;
		else if (got_magic != want_magic)
			v.status = ST_FORMAT;
		else if (got_version != want_version)
			v.status = ST_VERSION;
		else if (!rom_term || !app_term)
			v.status = ST_FORMAT;
		else if (got_length > 32'(limit_payload))
			v.status = ST_SIZE;
		else if (got_length > 32'(limit_capacity))
			v.status = ST_CAPACITY;
		else if (total != HDR_BYTES + longint'(got_length))
			v.status = (total < HDR_BYTES + longint'(got_length)) ? ST_TRUNCATED : ST_SIZE;
		else if (crc_out != got_crc)
			v.status = ST_CHECKSUM;
		else
			v.status = ST_OK;
		v.tick = got_tick;
		v.length = got_length;
		v.stored = got_crc;
		v.computed = crc_out;
		restart_parse();
		return 1'b1;
	endfunction

	task automatic note_mismatch(input string what, input logic [63:0] want_v,
			input logic [63:0] got_v);
		mismatches++;
		if (mismatches <= 10)
			$display("Mismatch on %s: expected %0h, got %0h", what, want_v, got_v);
	endtask

	// Watches all three channels at each rising edge. Register writes and
	// bytes update the local copy as they are accepted; result words are
	// checked against the oldest pending verdict.
	always @(posedge clk) begin
		verdict_t want;
		file_tag_t tag;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_MAGIC: want_magic = cfg_data;
					CFG_VERSION: want_version = cfg_data;
					CFG_MAX_PAY: limit_payload = cfg_data[SIZE_BITS-1:0];
					CFG_CAPACITY: limit_capacity = cfg_data[SIZE_BITS-1:0];
					default: ;
				endcase
			end
			if (byte_valid && byte_ready) begin
				if (absorb_byte(data_byte, last_byte, want)) begin
					tag = (file_tags.size() != 0) ? file_tags.pop_front() : '0;
					// Directed rows with a status typed in are held to it.
					if (tag.typed)
						want.status = tag.st;
					expected_verdicts.push_back(want);
				end
			end
			if (result_valid && result_ready) begin
				if (expected_verdicts.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("Result word with no file behind it: status %0d", status);
				end else begin
					want = expected_verdicts.pop_front();
					if (status != want.status)
						note_mismatch("status", 64'(want.status), 64'(status));
					if (tick != want.tick)
						note_mismatch("tick", want.tick, tick);
					if (declared_length != want.length)
						note_mismatch("declared_length", 64'(want.length),
							64'(declared_length));
					if (stored_crc != want.stored)
						note_mismatch("stored_crc", 64'(want.stored), 64'(stored_crc));
					if (computed_crc != want.computed)
						note_mismatch("computed_crc", 64'(want.computed),
							64'(computed_crc));
				end
			end
		end
	end

	// Result side: ready is dropped at random while stalls are
	// enabled, and stays high in the calm part at the end.
	initial begin
		forever begin
			@(posedge clk);
			if (rx_stalls && !calm && $urandom_range(0, 9) == 0) begin
				result_ready <= 1'b0;
				repeat ($urandom_range(1, 11)) begin
					@(posedge clk);
					if (calm)
						break;
				end
			end
			result_ready <= 1'b1;
		end
	end

	// Holds a register write until the port takes it. cfg_valid is left high
	// so back-to-back writes never lower and raise it in the same step.
	task automatic cfg_put(input logic [CFG_INDEX_BITS-1:0] idx, input logic [31:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic program_cfg(input cfg_set_t cs);
		// A write past the last register goes first and must change nothing.
		cfg_put(CFG_FIRST_UNUSED + 3'($urandom_range(0, 3)), $urandom);
		cfg_put(CFG_MAGIC, cs.magic);
		cfg_put(CFG_VERSION, cs.version);
		cfg_put(CFG_MAX_PAY, cs.max_pay);
		cfg_put(CFG_CAPACITY, cs.cap);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [31:0] pick_word();
		case ($urandom_range(0, 7))
			0: return 32'h0000_0000;
			1: return 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	// Size settings lean small so that most files can pass the size checks,
	// with the extremes and full-width writes mixed in.
	function automatic logic [31:0] pick_size();
		case ($urandom_range(0, 7))
			0: return 32'h0000_0000;
			1: return $urandom;
			2: return 32'h0100_0000;
			3: return 32'h01FF_FFFF;
			default: return $urandom_range(0, 30);
		endcase
	endfunction

	task automatic program_random_cfg();
		cfg_set_t cs;
		cs.magic = pick_word();
		cs.version = pick_word();
		cs.max_pay = pick_size();
		cs.cap = pick_size();
		program_cfg(cs);
	endtask

	// Lowers byte_valid and waits until every pending verdict has been
	// matched, then lets the pipeline settle.
	task automatic drain();
		byte_valid <= 1'b0;
		do @(posedge clk); while (expected_verdicts.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Presents one byte word and holds it until it is taken. A gap, when one
	// is drawn, comes before the word is raised.
	task automatic send_byte(input logic [7:0] b, input logic fin);
		if (tx_stalls && !calm && $urandom_range(0, 7) == 0) begin
			byte_valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		byte_valid <= 1'b1;
		data_byte <= b;
		last_byte <= fin;
		do @(posedge clk); while (!byte_ready);
	endtask

	function automatic logic [7:0] text_byte(input int fill, input logic want_zero,
			input bit at_mark);
		if (want_zero && (at_mark || fill == FILL_ZERO))
			return 8'h00;
		case (fill)
			FILL_ONES: return 8'hFF;
			FILL_ZERO: return 8'h01;
			default: return 8'($urandom_range(1, 255));
		endcase
	endfunction

	// Builds the bytes of one file from its description and sends them.
	task automatic send_file(input file_spec_t sp);
		logic [7:0] img[$];
		logic [7:0] pay[$];
		logic [7:0] hb;
		logic [31:0] crc;
		int zr;
		int za;
		int count;
		file_tag_t tag;
		for (int i = 0; i < sp.n_pay; i++) begin
			case (sp.fill)
				FILL_ZERO: pay.push_back(8'h00);
				FILL_ONES: pay.push_back(8'hFF);
				default: pay.push_back(8'($urandom_range(0, 255)));
			endcase
		end
		// Stored CRC covers the declared payload, as far as it is sent.
		crc = CRC_ALL_ONES;
		for (int i = 0; i < sp.n_pay && longint'(i) < longint'(sp.length); i++)
			crc = crc32_step(crc, pay[i]);
		crc = crc ^ CRC_ALL_ONES;
		if (!sp.crc_good)
			crc = crc ^ (32'h1 << $urandom_range(0, 31));
		zr = $urandom_range(0, APP_TEXT_POS - ROM_TEXT_POS - 1);
		za = $urandom_range(0, TICK_POS - APP_TEXT_POS - 1);
		for (int i = 0; i < HDR_BYTES; i++) begin
			if (i < VERSION_POS)
				hb = sp.magic[8*i +: 8];
			else if (i < ROM_TEXT_POS)
				hb = sp.version[8*(i - VERSION_POS) +: 8];
			else if (i < APP_TEXT_POS)
				hb = text_byte(sp.fill, sp.rom_zero, (i - ROM_TEXT_POS) == zr);
			else if (i < TICK_POS)
				hb = text_byte(sp.fill, sp.app_zero, (i - APP_TEXT_POS) == za);
			else if (i < LENGTH_POS)
				hb = sp.tick[8*(i - TICK_POS) +: 8];
			else if (i < CRC_POS)
				hb = sp.length[8*(i - LENGTH_POS) +: 8];
			else
				hb = crc[8*(i - CRC_POS) +: 8];
			img.push_back(hb);
		end
		foreach (pay[i])
			img.push_back(pay[i]);
		count = (sp.cut < HDR_BYTES) ? sp.cut : HDR_BYTES + sp.n_pay;
		tag.typed = sp.typed;
		tag.st = sp.st;
		file_tags.push_back(tag);
		for (int i = 0; i < count; i++)
			send_byte(img[i], i == count - 1);
		bytes_sent += count;
		files_sent++;
	endtask

	// Random file shaped by the current registers. About half are well formed,
	// most of the rest break one rule, and a few are pure noise.
	function automatic file_spec_t random_file();
		file_spec_t sp;
		logic [31:0] lim;
		int k;
		sp.cfg_sel = -1;
		sp.magic = want_magic;
		sp.version = want_version;
		sp.rom_zero = 1'b1;
		sp.app_zero = 1'b1;
		sp.tick = {$urandom, $urandom};
		lim = (limit_payload < limit_capacity) ? 32'(limit_payload) : 32'(limit_capacity);
		if (lim > 24)
			lim = 24;
		sp.length = $urandom_range(0, lim);
		sp.crc_good = 1'b1;
		sp.cut = HDR_BYTES;
		sp.n_pay = int'(sp.length);
		k = $urandom_range(0, 15);
		sp.fill = (k == 0) ? FILL_ZERO : (k == 1) ? FILL_ONES : FILL_RAND;
		sp.typed = 1'b0;
		sp.st = ST_OK;
		k = $urandom_range(0, 99);
		if (k < 52) begin
			// Well formed as it stands.
		end else if (k < 57) begin
			sp.cut = $urandom_range(1, HDR_BYTES - 1);
		end else if (k < 61) begin
			sp.magic = sp.magic ^ (32'h1 << $urandom_range(0, 31));
		end else if (k < 65) begin
			sp.version = sp.version ^ (32'h1 << $urandom_range(0, 31));
		end else if (k < 68) begin
			sp.rom_zero = 1'b0;
		end else if (k < 71) begin
			sp.app_zero = 1'b0;
		end else if (k < 76) begin
			// Over the ceiling, either just above it or far beyond any setting.
			if ($urandom_range(0, 1) == 0 || limit_payload == '1)
				sp.length = $urandom | 32'h0200_0000;
			else
				sp.length = 32'(limit_payload) + 32'($urandom_range(1, 3));
			sp.n_pay = $urandom_range(0, 8);
		end else if (k < 80) begin
			if (limit_capacity < limit_payload) begin
				sp.length = 32'(limit_capacity) + 1;
				sp.n_pay = (sp.length <= 24) ? int'(sp.length) : $urandom_range(0, 8);
			end else
				sp.crc_good = 1'b0;
		end else if (k < 85) begin
			if (sp.n_pay != 0)
				sp.n_pay = $urandom_range(0, sp.n_pay - 1);
			else
				sp.cut = $urandom_range(1, HDR_BYTES - 1);
		end else if (k < 90) begin
			sp.n_pay = sp.n_pay + $urandom_range(1, 6);
		end else if (k < 95) begin
			sp.crc_good = 1'b0;
		end else begin
			sp.magic = $urandom;
			sp.version = $urandom;
			sp.rom_zero = 1'($urandom_range(0, 1));
			sp.app_zero = 1'($urandom_range(0, 1));
			sp.length = ($urandom_range(0, 1) == 0) ? $urandom : $urandom_range(0, 12);
			sp.n_pay = $urandom_range(0, 12);
			sp.crc_good = 1'($urandom_range(0, 1));
		end
		return sp;
	endfunction

	initial begin
		restart_parse();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table. A row that names a register set first lets the block
		// go idle and then reprograms it.
		for (int r = 0; r < DIR_ROWS; r++) begin
			if (dir_tbl[r].cfg_sel >= 0) begin
				drain();
				program_cfg(cfg_tbl[dir_tbl[r].cfg_sel]);
			end
			send_file(dir_tbl[r]);
		end

		// Random phases. Each one starts from an idle block, so the sender
		// also waits here for every pending result before moving on.
		while (bytes_sent < RANDOM_BYTES || files_sent < RANDOM_FILES) begin
			drain();
			program_random_cfg();
			tx_stalls = ($urandom_range(0, 3) != 0);
			rx_stalls = ($urandom_range(0, 3) != 0);
			repeat ($urandom_range(1, 3))
				send_file(random_file());
		end

		// Last stretch runs at full rate on both sides.
		drain();
		calm = 1'b1;
		program_random_cfg();
		repeat (CALM_FILES)
			send_file(random_file());

		drain();
		if (mismatches == 0 && expected_verdicts.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	// Stop a hung run well after the slowest legal one would have ended.
	initial begin
		#10_000_000;
		$display("Test completed with failures");
		$finish;
	end

endmodule

FILE: files.f
design/ssc_pkg.sv
design/ssc_hdr.sv
design/ssc_crc32.sv
design/ssc_judge.sv
design/save_state_stream_checker_top.sv
test/tb_save_state_stream_checker_top.sv
